>>> design/pidp_pkg.sv
// ---------------------------------------------------------------------------
// PID positional controller package
// Shared widths, item types and the 32-bit saturation helper.
// ---------------------------------------------------------------------------
package pidp_pkg;

    localparam int SAMPLE_WIDTH   = 16;
    localparam int GAIN_FRAC_BITS = 8;
    localparam int GAIN_W         = 16;
    localparam int DRIVE_W        = 32;
    localparam int ERR_W          = SAMPLE_WIDTH + 1;
    localparam int DIFF_W         = SAMPLE_WIDTH + 2;
    localparam int PROP_W         = GAIN_W + ERR_W;
    localparam int INTEG_W        = GAIN_W + DRIVE_W;
    localparam int DERIV_W        = GAIN_W + DIFF_W;
    localparam int ACC_W          = INTEG_W + 2;
    localparam int IN_TDATA_W     = ((2 * SAMPLE_WIDTH + 7) / 8) * 8;
    localparam int OUT_TDATA_W    = 2 * DRIVE_W;
    localparam int CFG_INDEX_W    = 2;
    localparam int QUEUE_DEPTH    = 4;
    localparam int QUEUE_AW       = $clog2(QUEUE_DEPTH);

    localparam logic [CFG_INDEX_W-1:0] REG_GAIN_PROP  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_GAIN_INTEG = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_GAIN_DERIV = 2'd2;

    typedef struct packed {
        logic signed [GAIN_W-1:0] prop;
        logic signed [GAIN_W-1:0] integ;
        logic signed [GAIN_W-1:0] deriv;
    } t_gains;

    typedef struct packed {
        logic signed [ERR_W-1:0]   err;
        logic signed [DRIVE_W-1:0] integ;
        logic signed [DIFF_W-1:0]  diff;
    } t_front_item;

    function automatic logic signed [DRIVE_W-1:0] sat_drive(
        input logic signed [DRIVE_W:0] x
    );
        logic signed [DRIVE_W-1:0] r;
        if (x[DRIVE_W] == x[DRIVE_W-1]) begin
            r = x[DRIVE_W-1:0];
        end else if (x[DRIVE_W]) begin
            r = {1'b1, {(DRIVE_W-1){1'b0}}};
        end else begin
            r = {1'b0, {(DRIVE_W-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

>>> design/pid_positional_controller.sv
// An accepted request passes the queue, then the product, sum and output registers.
// Throughput: one request per cycle unless output stalls; the three-stage back end sets the pace.
// A four-entry queue decouples the input handshake from output stalls.
// Reset (synchronous, active low) clears the gains, integral, last error,
// last drive, queue and pipeline valid flags.
// ---------------------------------------------------------------------------
// PID positional controller
// Top level: gain registers, front end, queue and back-end pipeline.
// ---------------------------------------------------------------------------
module pid_positional_controller import pidp_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // target_value [15:0], measured_value [31:16]
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // drive_value [31:0], drive_change [63:32]
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [GAIN_W-1:0]      i_cfg_data
);

    t_gains      r_gains;
    t_front_item front_item;
    t_front_item queue_item;
    logic        push;
    logic        pop;
    logic        queue_full;
    logic        queue_empty;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gains <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_GAIN_PROP:  r_gains.prop  <= i_cfg_data;
                REG_GAIN_INTEG: r_gains.integ <= i_cfg_data;
                REG_GAIN_DERIV: r_gains.deriv <= i_cfg_data;
                default:        r_gains       <= r_gains;
            endcase
        end
    end

    pidp_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_queue_full    (queue_full),
        .o_push          (push),
        .o_item          (front_item)
    );

    pidp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .o_full  (queue_full),
        .i_pop   (pop),
        .o_empty (queue_empty),
        .o_item  (queue_item)
    );

    pidp_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_gains         (r_gains),
        .i_queue_empty   (queue_empty),
        .i_item          (queue_item),
        .o_pop           (pop),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

endmodule

>>> design/pidp_front.sv
// ---------------------------------------------------------------------------
// PID front end
// Accepts samples, forms the error, the saturated integral and the change
// in error, and pushes them into the queue.
// ---------------------------------------------------------------------------
module pidp_front import pidp_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // target_value, measured_value
    input  logic [IN_TDATA_W-1:0] i_s_axis_tdata,
    input  logic                  i_queue_full,
    output logic                  o_push,
    output t_front_item           o_item
);

    logic signed [DRIVE_W-1:0] r_integ;
    logic signed [ERR_W-1:0]   r_last_err;
    logic signed [SAMPLE_WIDTH-1:0] target;
    logic signed [SAMPLE_WIDTH-1:0] measured;
    logic signed [ERR_W-1:0]   err;
    logic signed [DRIVE_W:0]   integ_sum;
    logic signed [DRIVE_W-1:0] n_integ;

    assign target    = i_s_axis_tdata[SAMPLE_WIDTH-1:0];
    assign measured  = i_s_axis_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH];
    assign err       = ERR_W'(target) - ERR_W'(measured);
    assign integ_sum = (DRIVE_W+1)'(r_integ) + (DRIVE_W+1)'(err);
    assign n_integ   = sat_drive(integ_sum);

    assign o_s_axis_tready = !i_queue_full;
    assign o_push          = i_s_axis_tvalid && !i_queue_full;
    assign o_item.err      = err;
    assign o_item.integ    = n_integ;
    assign o_item.diff     = DIFF_W'(err) - DIFF_W'(r_last_err);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ    <= '0;
            r_last_err <= '0;
        end else if (o_push) begin
            r_integ    <= n_integ;
            r_last_err <= err;
        end
    end

endmodule

>>> design/pidp_queue.sv
// ---------------------------------------------------------------------------
// PID item queue
// Small first-in first-out buffer between the front end and the back end.
// ---------------------------------------------------------------------------
module pidp_queue import pidp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  t_front_item i_item,
    output logic        o_full,
    input  logic        i_pop,
    output logic        o_empty,
    output t_front_item o_item
);

    t_front_item               r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]       r_wr_ptr;
    logic [QUEUE_AW-1:0]       r_rd_ptr;
    logic [QUEUE_AW:0]         r_count;
    logic                      do_pop;

    assign o_full  = (r_count == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QUEUE_AW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + QUEUE_AW'(1);
            end
            unique case ({i_push, do_pop})
                2'b10:   r_count <= r_count + (QUEUE_AW+1)'(1);
                2'b01:   r_count <= r_count - (QUEUE_AW+1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

>>> design/pidp_back.sv
// ---------------------------------------------------------------------------
// PID back end
// Three-stage pipeline: gain products, shifted and saturated sum, and the
// saturated change against the previous drive in the output register.
// ---------------------------------------------------------------------------
module pidp_back import pidp_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_gains                 i_gains,
    input  logic                   i_queue_empty,
    input  t_front_item            i_item,
    output logic                   o_pop,
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // drive_value, drive_change
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata
);

    logic                       r_v1;
    logic                       r_v2;
    logic                       r_v3;
    logic signed [PROP_W-1:0]   r_p_prop;
    logic signed [INTEG_W-1:0]  r_p_integ;
    logic signed [DERIV_W-1:0]  r_p_deriv;
    logic signed [DRIVE_W-1:0]  r_drive2;
    logic signed [DRIVE_W-1:0]  r_drive3;
    logic signed [DRIVE_W-1:0]  r_change3;
    logic signed [DRIVE_W-1:0]  r_last_drive;
    logic                       ready1;
    logic                       ready2;
    logic                       ready3;
    logic signed [ACC_W-1:0]    acc;
    logic signed [ACC_W-1:0]    shifted;
    logic signed [DRIVE_W-1:0]  n_drive2;

    assign ready3 = !r_v3 || i_m_axis_tready;
    assign ready2 = !r_v2 || ready3;
    assign ready1 = !r_v1 || ready2;
    assign o_pop  = ready1 && !i_queue_empty;

    assign acc     = ACC_W'(r_p_prop) + ACC_W'(r_p_integ) + ACC_W'(r_p_deriv);
    assign shifted = acc >>> GAIN_FRAC_BITS;

    always_comb begin
        if (&shifted[ACC_W-1:DRIVE_W-1] || ~|shifted[ACC_W-1:DRIVE_W-1]) begin
            n_drive2 = shifted[DRIVE_W-1:0];
        end else if (shifted[ACC_W-1]) begin
            n_drive2 = {1'b1, {(DRIVE_W-1){1'b0}}};
        end else begin
            n_drive2 = {1'b0, {(DRIVE_W-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready1) begin
            r_p_prop  <= i_gains.prop * i_item.err;
            r_p_integ <= i_gains.integ * i_item.integ;
            r_p_deriv <= i_gains.deriv * i_item.diff;
        end
        if (ready2) begin
            r_drive2 <= n_drive2;
        end
        if (ready3 && r_v2) begin
            r_drive3  <= r_drive2;
            r_change3 <= sat_drive((DRIVE_W+1)'(r_drive2) - (DRIVE_W+1)'(r_last_drive));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1         <= 1'b0;
            r_v2         <= 1'b0;
            r_v3         <= 1'b0;
            r_last_drive <= '0;
        end else begin
            if (ready1) begin
                r_v1 <= !i_queue_empty;
            end
            if (ready2) begin
                r_v2 <= r_v1;
            end
            if (ready3) begin
                r_v3 <= r_v2;
                if (r_v2) begin
                    r_last_drive <= r_drive2;
                end
            end
        end
    end

    assign o_m_axis_tvalid = r_v3;
    assign o_m_axis_tdata  = {r_change3, r_drive3};

endmodule
